>>> hdl/rpvg_pkg.sv
// ----------------------------------------------------------------------------
// rpvg_pkg
// shared constants, types and the arctangent table of the polygon generator
// ----------------------------------------------------------------------------
package rpvg_pkg;

   localparam int MAX_SIDES = 64;
   localparam int TRIG_BITS = 16;
   localparam int TURN64    = 23040;
   localparam longint GAIN_Q30 = 652032874;

   localparam int SIDE_W  = 7;
   localparam int ANG_W   = 21;
   localparam int PHASE_W = 32;
   localparam int XY_W    = TRIG_BITS + 4;
   localparam int Z_W     = 32;
   localparam int TRIG_W  = TRIG_BITS + 2;
   localparam int CIDX_W  = $clog2(TRIG_BITS);
   localparam int CNT_W   = $clog2(PHASE_W + 1);
   localparam int POS_W   = 21;

   localparam longint X_INIT =
      (GAIN_Q30 + (longint'(1) << (29 - TRIG_BITS))) >>> (30 - TRIG_BITS);

   localparam logic CSR_SIDE_COUNT  = 1'b0;
   localparam logic CSR_START_ANGLE = 1'b1;

   typedef struct packed {
      logic                   valid;
      logic [1:0]             quad;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_type;

   function automatic logic [Z_W-1:0] atan_turn(input logic [CIDX_W-1:0] idx);
      logic [Z_W-1:0] r;
      case (5'(idx))
         5'd0:    r = 32'd536870912;
         5'd1:    r = 32'd316933406;
         5'd2:    r = 32'd167458907;
         5'd3:    r = 32'd85004756;
         5'd4:    r = 32'd42667331;
         5'd5:    r = 32'd21354465;
         5'd6:    r = 32'd10679838;
         5'd7:    r = 32'd5340245;
         5'd8:    r = 32'd2670163;
         5'd9:    r = 32'd1335087;
         5'd10:   r = 32'd667544;
         5'd11:   r = 32'd333772;
         5'd12:   r = 32'd166886;
         5'd13:   r = 32'd83443;
         5'd14:   r = 32'd41722;
         5'd15:   r = 32'd20861;
         5'd16:   r = 32'd10430;
         5'd17:   r = 32'd5215;
         5'd18:   r = 32'd2608;
         5'd19:   r = 32'd1304;
         5'd20:   r = 32'd652;
         5'd21:   r = 32'd326;
         5'd22:   r = 32'd163;
         5'd23:   r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/rpvg_cordic_cell.sv
// ----------------------------------------------------------------------------
// rpvg_cordic_cell
// one rotation step of the cordic chain, registered towards the next cell
// ----------------------------------------------------------------------------
module rpvg_cordic_cell
   import rpvg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [CIDX_W-1:0] cell_index,
   input  cordic_type        cell_in,
   output cordic_type        cell_out
);

   cordic_type step_ff, step_in;
   logic signed [XY_W-1:0] dx, dy;
   logic signed [Z_W-1:0]  angle;

   always_comb begin
      dx = cell_in.y >>> cell_index;
      dy = cell_in.x >>> cell_index;
      angle = signed'(atan_turn(cell_index));
      step_in = cell_in;
      if (!cell_in.z[Z_W-1]) begin
         step_in.x = cell_in.x - dx;
         step_in.y = cell_in.y + dy;
         step_in.z = cell_in.z - angle;
      end else begin
         step_in.x = cell_in.x + dx;
         step_in.y = cell_in.y - dy;
         step_in.z = cell_in.z + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else begin
         step_ff.valid <= step_in.valid;
      end
      step_ff.quad <= step_in.quad;
      step_ff.x    <= step_in.x;
      step_ff.y    <= step_in.y;
      step_ff.z    <= step_in.z;
   end

   assign cell_out = step_ff;

endmodule

>>> hdl/rpvg_divider.sv
// ----------------------------------------------------------------------------
// rpvg_divider
// bit-serial restoring divider turning a vertex angle into a 32-bit phase
// ----------------------------------------------------------------------------
module rpvg_divider
   import rpvg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               div_go,
   input  logic [ANG_W-1:0]   angle,
   input  logic [ANG_W-1:0]   full_turn,
   output logic               div_done,
   output logic [PHASE_W-1:0] phase
);

   logic [ANG_W-1:0]   rem_ff, rem_in;
   logic [PHASE_W-1:0] num_ff, num_in;
   logic [PHASE_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [ANG_W:0]     trial;

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[PHASE_W-1]};
      if (div_go) begin
         rem_in = angle;
         num_in = PHASE_W'(full_turn >> 1);
         cnt_in = CNT_W'(PHASE_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, full_turn}) begin
            rem_in = ANG_W'(trial - {1'b0, full_turn});
            quo_in = {quo_ff[PHASE_W-2:0], 1'b1};
         end else begin
            rem_in = ANG_W'(trial);
            quo_in = {quo_ff[PHASE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign div_done = done_ff;
   assign phase    = quo_ff;

endmodule

>>> hdl/regular_polygon_vertex_generator.sv
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator
// vertices of a regular polygon inscribed in the ellipse of a bounding box
// ----------------------------------------------------------------------------
// a request (box_x, box_y, box_width, box_height) is taken when start is high
// and busy is low; busy stays high until the last vertex has been issued
// side_count and start_angle are written on the csr channel while idle;
// csr_ready is always high
// one vertex per angle, side_count of them (clamped to 3 .. MAX_SIDES),
// each on the rsp ports for one cycle with rsp_valid; the first carries
// rsp_starts_path, the last rsp_closes_path
// each vertex passes through a load and 32 steps of the phase divider, the
// cordic cells, then quadrant, multiply and output registers; the vertices
// of a request are worked one after another and the next request can be
// taken while its last vertex is on the rsp ports
// results cannot be held off by the receiver and are never retried
// reset clears the sequencer, the pipeline valids and the registers to
// side_count 3 and start_angle 0
// ----------------------------------------------------------------------------
module regular_polygon_vertex_generator
   import rpvg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [15:0]     req_box_x,
   input  logic signed [15:0]     req_box_y,
   input  logic [14:0]            req_box_width,
   input  logic [14:0]            req_box_height,
   output logic                   rsp_valid,
   output logic signed [POS_W-1:0] rsp_vertex_x,
   output logic signed [POS_W-1:0] rsp_vertex_y,
   output logic                   rsp_starts_path,
   output logic                   rsp_closes_path,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [15:0]            csr_data
);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_WAIT} state_type;

   localparam int PROD_W = TRIG_W + 19;
   localparam logic signed [XY_W-1:0] ONE = XY_W'(1) <<< TRIG_BITS;

   state_type state_ff;
   logic [SIDE_W-1:0]  side_count_ff;
   logic [15:0]        start_angle_ff;
   logic [SIDE_W-1:0]  sides_ff, sides_in;
   logic [ANG_W-1:0]   full_ff, acc_ff, acc_start, acc_next;
   logic [ANG_W:0]     acc_sum;
   logic [SIDE_W-1:0]  index_ff;
   logic               div_go_ff;
   logic signed [15:0] bx_ff, by_ff;
   logic [14:0]        bw_ff, bh_ff;
   logic signed [16:0] ang0, ang1, ang2, ang3;

   logic               rsp_valid_ff, starts_ff, closes_ff;
   logic [POS_W-1:0]   vx_ff, vy_ff;

   logic               div_done;
   logic [PHASE_W-1:0] phase;

   cordic_type chain [TRIG_BITS+1];

   logic signed [XY_W-1:0]   cx, cy;
   logic signed [TRIG_W-1:0] tc, ts, tc_ff, ts_ff;
   logic                     a_valid_ff, b_valid_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff;
   logic signed [PROD_W:0]   rx, ry;
   logic signed [21:0]       centre_x, centre_y, pos_x, pos_y;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         side_count_ff  <= SIDE_W'(3);
         start_angle_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SIDE_COUNT:  side_count_ff  <= csr_data[SIDE_W-1:0];
            CSR_START_ANGLE: start_angle_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // clamp side count, fold start angle into one turn and advance the vertex angle
   always_comb begin
      sides_in = side_count_ff;
      if (side_count_ff < SIDE_W'(3)) sides_in = SIDE_W'(3);
      if (side_count_ff > SIDE_W'(MAX_SIDES)) sides_in = SIDE_W'(MAX_SIDES);
      ang0 = {start_angle_ff[15], start_angle_ff};
      ang1 = ang0[16] ? ang0 + 17'(TURN64) : ang0;
      ang2 = ang1[16] ? ang1 + 17'(TURN64) : ang1;
      ang3 = (ang2 >= 17'(TURN64)) ? ang2 - 17'(TURN64) : ang2;
      acc_start = ANG_W'(ang3[14:0]) * ANG_W'(sides_in);
      acc_sum   = {1'b0, acc_ff} + (ANG_W+1)'(TURN64);
      acc_next  = (acc_sum >= {1'b0, full_ff}) ? ANG_W'(acc_sum - {1'b0, full_ff})
                                               : ANG_W'(acc_sum);
   end

   rpvg_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_go    (div_go_ff),
      .angle     (acc_ff),
      .full_turn (full_ff),
      .div_done  (div_done),
      .phase     (phase)
   );

   always_comb begin
      chain[0].valid = div_done;
      chain[0].quad  = phase[PHASE_W-1:PHASE_W-2];
      chain[0].x     = XY_W'(X_INIT);
      chain[0].y     = '0;
      chain[0].z     = signed'({2'b00, phase[PHASE_W-3:0]});
   end

   for (genvar i = 0; i < TRIG_BITS; i++) begin : g_cell
      rpvg_cordic_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CIDX_W'(i)),
         .cell_in    (chain[i]),
         .cell_out   (chain[i+1])
      );
   end

   // clamp and quadrant
   always_comb begin
      cx = chain[TRIG_BITS].x;
      cy = chain[TRIG_BITS].y;
      if (cx > ONE) cx = ONE;
      if (cx < -ONE) cx = -ONE;
      if (cy > ONE) cy = ONE;
      if (cy < -ONE) cy = -ONE;
      case (chain[TRIG_BITS].quad)
         2'd0: begin tc = cx[TRIG_W-1:0];    ts = cy[TRIG_W-1:0];    end
         2'd1: begin tc = -cy[TRIG_W-1:0];   ts = cx[TRIG_W-1:0];    end
         2'd2: begin tc = -cx[TRIG_W-1:0];   ts = -cy[TRIG_W-1:0];   end
         default: begin tc = cy[TRIG_W-1:0]; ts = -cx[TRIG_W-1:0];   end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= chain[TRIG_BITS].valid;
         b_valid_ff <= a_valid_ff;
      end
      tc_ff <= tc;
      ts_ff <= ts;
      px_ff <= PROD_W'(tc_ff) * PROD_W'(signed'({1'b0, bw_ff, 3'b000}));
      py_ff <= PROD_W'(ts_ff) * PROD_W'(signed'({1'b0, bh_ff, 3'b000}));
   end

   // round, add centre
   always_comb begin
      rx = ({px_ff[PROD_W-1], px_ff} + (PROD_W+1)'(1 << (TRIG_BITS - 1))) >>> TRIG_BITS;
      ry = ({py_ff[PROD_W-1], py_ff} + (PROD_W+1)'(1 << (TRIG_BITS - 1))) >>> TRIG_BITS;
      centre_x = {{2{bx_ff[15]}}, bx_ff, 4'b0000} + {4'b0000, bw_ff, 3'b000};
      centre_y = {{2{by_ff[15]}}, by_ff, 4'b0000} + {4'b0000, bh_ff, 3'b000};
      pos_x = centre_x + rx[21:0];
      pos_y = centre_y + ry[21:0];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  bx_ff     <= req_box_x;
                  by_ff     <= req_box_y;
                  bw_ff     <= req_box_width;
                  bh_ff     <= req_box_height;
                  sides_ff  <= sides_in;
                  full_ff   <= ANG_W'(TURN64) * ANG_W'(sides_in);
                  acc_ff    <= acc_start;
                  index_ff  <= '0;
                  div_go_ff <= 1'b1;
                  state_ff  <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (b_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  vx_ff        <= pos_x[POS_W-1:0];
                  vy_ff        <= pos_y[POS_W-1:0];
                  starts_ff    <= (index_ff == '0);
                  closes_ff    <= (index_ff == sides_ff - 1'b1);
                  if (index_ff == sides_ff - 1'b1) begin
                     state_ff <= S_IDLE;
                  end else begin
                     index_ff  <= index_ff + 1'b1;
                     acc_ff    <= acc_next;
                     div_go_ff <= 1'b1;
                     state_ff  <= S_DIV;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vertex_x    = signed'(vx_ff);
   assign rsp_vertex_y    = signed'(vy_ff);
   assign rsp_starts_path = starts_ff;
   assign rsp_closes_path = closes_ff;

`ifndef SYNTHESIS
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back vertices");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request not taken");
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("divider done out of turn");
   a_pipe_state: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> state_ff == S_WAIT) else $error("stray vertex in pipeline");
`endif

endmodule

>>> tb/regular_polygon_vertex_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator_tb
// self-checking bench: directed rows then random boxes under changing
// side counts and start angles; every vertex is checked against a
// bit-exact cordic predictor or a row's fixed values, in order, field by field
// ----------------------------------------------------------------------------
module regular_polygon_vertex_generator_tb;
   import rpvg_pkg::*;

   localparam int  HALF_PERIOD = 6;
   localparam int  CYCLE_LIMIT = 2000000;
   localparam int  SETTLE      = PHASE_W + TRIG_BITS + 10;
   localparam int  PHASES      = 16;
   localparam int  PER_PHASE   = 10;

   typedef struct {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic                    sp;
      logic                    cp;
   } vertex_type;

   typedef struct {
      logic [15:0]        sides;
      logic signed [15:0] angle;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic [14:0]        bw;
      logic [14:0]        bh;
      bit                 fixed;
      int                 ex;
      int                 ey;
   } row_type;

   localparam longint ATAN_TURN [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic signed [15:0]      req_box_x = '0;
   logic signed [15:0]      req_box_y = '0;
   logic [14:0]             req_box_width = '0;
   logic [14:0]             req_box_height = '0;
   logic                    rsp_valid;
   logic signed [POS_W-1:0] rsp_vertex_x;
   logic signed [POS_W-1:0] rsp_vertex_y;
   logic                    rsp_starts_path;
   logic                    rsp_closes_path;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic                    csr_index = CSR_SIDE_COUNT;
   logic [15:0]             csr_data = '0;

   logic [6:0]              cfg_sides = 7'd3;
   logic signed [15:0]      cfg_angle = '0;
   vertex_type              vertex_q[$];
   int                      errors = 0;
   int                      cycles = 0;

   regular_polygon_vertex_generator DUT (.*);

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int trig_frac();
      int f;
      f = TRIG_BITS;
      if (f < 8) f = 8;
      if (f > 24) f = 24;
      return f;
   endfunction

   // queue the vertices one request produces
   task automatic predict_vertices(input logic signed [15:0] bx, input logic signed [15:0] by,
                                   input logic [14:0] bw, input logic [14:0] bh,
                                   input bit fixed, input int ex, input int ey);
      int      f, n, k, i;
      longint  full, acc, x, y, z, one, c, s, vx, vy, w, h;
      longint unsigned num;
      logic [31:0] phase;
      vertex_type v;
      f = trig_frac();
      n = cfg_sides;
      if (n < 3) n = 3;
      if (n > MAX_SIDES) n = MAX_SIDES;
      full = longint'(TURN64) * n;
      acc = (longint'(cfg_angle) * n) % full;
      if (acc < 0) acc += full;
      w = bw;
      h = bh;
      for (k = 0; k < n; k++) begin
         num = (longint'(acc) << 32) + longint'(full / 2);
         phase = 32'(num / longint'(full));
         one = longint'(1) << f;
         x = (GAIN_Q30 + (longint'(1) << (29 - f))) >>> (30 - f);
         y = 0;
         z = phase[29:0];
         for (i = 0; i < f; i++) begin
            c = y >>> i;
            s = x >>> i;
            if (z >= 0) begin
               x -= c; y += s; z -= ATAN_TURN[i];
            end else begin
               x += c; y -= s; z += ATAN_TURN[i];
            end
         end
         if (x > one) x = one;
         if (x < -one) x = -one;
         if (y > one) y = one;
         if (y < -one) y = -one;
         case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
         vx = longint'(bx) * 16 + w * 8 + ((c * w * 8 + (longint'(1) << (f - 1))) >>> f);
         vy = longint'(by) * 16 + h * 8 + ((s * h * 8 + (longint'(1) << (f - 1))) >>> f);
         v.x = fixed ? POS_W'(ex) : POS_W'(vx);
         v.y = fixed ? POS_W'(ey) : POS_W'(vy);
         v.sp = (k == 0);
         v.cp = (k == n - 1);
         vertex_q = {vertex_q, v};
         acc += TURN64;
         if (acc >= full) acc -= full;
      end
   endtask

   always @(posedge clock) begin
      vertex_type v;
      if (!reset && rsp_valid) begin
         if (vertex_q.size() == 0) begin
            $error("unexpected vertex x=%0d y=%0d", rsp_vertex_x, rsp_vertex_y);
            errors++;
         end else begin
            v = vertex_q.pop_front();
            if (rsp_vertex_x !== v.x) begin
               $error("vertex_x expected %0d got %0d", v.x, rsp_vertex_x);
               errors++;
            end
            if (rsp_vertex_y !== v.y) begin
               $error("vertex_y expected %0d got %0d", v.y, rsp_vertex_y);
               errors++;
            end
            if (rsp_starts_path !== v.sp) begin
               $error("starts_path expected %0b got %0b", v.sp, rsp_starts_path);
               errors++;
            end
            if (rsp_closes_path !== v.cp) begin
               $error("closes_path expected %0b got %0b", v.cp, rsp_closes_path);
               errors++;
            end
         end
      end
   end

   task automatic pause_random();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return;
      repeat (r < 9 ? $urandom_range(1, 3) : $urandom_range(20, 200)) @(posedge clock);
   endtask

   task automatic wait_idle();
      while (vertex_q.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_SIDE_COUNT) cfg_sides = data[6:0];
      else cfg_angle = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(input logic signed [15:0] bx, input logic signed [15:0] by,
                               input logic [14:0] bw, input logic [14:0] bh,
                               input bit fixed, input int ex, input int ey);
      start          <= 1'b1;
      req_box_x      <= bx;
      req_box_y      <= by;
      req_box_width  <= bw;
      req_box_height <= bh;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_vertices(bx, by, bw, bh, fixed, ex, ey);
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [14:0] rand_extent();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return 15'h7fff;
      return 15'($urandom);
   endfunction

   row_type directed_rows[] = '{
      '{3,      0,      0,      0,     0,     0,     1, 0,       0},
      '{3,      0, -32768,  32767,     0,     0,     1, -524288, 524272},
      '{0,      0,    100,    -50,   200,    80,     0, 0,       0},
      '{1,   5760,    -10,     10,    64,    64,     0, 0,       0},
      '{2,  -5760,      0,      0, 32767, 32767,     0, 0,       0},
      '{4,  23040, -32768, -32768, 32767, 32767,     0, 0,       0},
      '{5, -23040,  32767,  32767, 32767, 32767,     0, 0,       0},
      '{6,  32767,     12,     34,     0,   500,     0, 0,       0},
      '{7, -32768,    -12,    -34,   500,     0,     0, 0,       0},
      '{64,   100,      0,      0,  1000,  2000,     0, 0,       0},
      '{65,     0,     -1,     -1,   301,   299,     0, 0,       0},
      '{127,   -1,   1234,  -4321, 32767,     1,     0, 0,       0},
      '{16'hff83, 11520, 0,      0,     1, 32767,     0, 0,       0},
      '{8,  16'sh5555, 16'sh2aaa, -16'sh2aab, 15'h2aaa, 15'h5555, 0, 0, 0}
   };

   initial begin
      int p, k;
      logic [15:0] sides_word;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (i > 0) begin
            wait_idle();
            write_csr(CSR_SIDE_COUNT, directed_rows[i].sides);
            write_csr(CSR_START_ANGLE, directed_rows[i].angle);
         end
         send_request(directed_rows[i].bx, directed_rows[i].by, directed_rows[i].bw,
                      directed_rows[i].bh, directed_rows[i].fixed,
                      directed_rows[i].ex, directed_rows[i].ey);
         pause_random();
      end

      for (p = 0; p < PHASES; p++) begin
         wait_idle();
         k = $urandom_range(0, 9);
         sides_word = 16'($urandom) & 16'hff80;
         if (k < 6) sides_word |= 16'($urandom_range(3, 10));
         else if (k == 6) sides_word |= 16'($urandom_range(0, 2));
         else if (k == 7) sides_word |= 16'(MAX_SIDES);
         else if (k == 8) sides_word |= 16'($urandom_range(65, 127));
         else sides_word |= 16'($urandom_range(11, 40));
         write_csr(CSR_SIDE_COUNT, sides_word);
         write_csr(CSR_START_ANGLE, $urandom_range(0, 3) == 0 ? 16'($urandom)
                                   : 16'($signed($urandom_range(0, 46080)) - 23040));
         for (k = 0; k < PER_PHASE; k++) begin
            send_request(16'($urandom), 16'($urandom), rand_extent(), rand_extent(),
                         0, 0, 0);
            pause_random();
         end
      end

      wait_idle();
      if (errors == 0 && vertex_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
